// ===== hw/rtl/cht_pkg.sv =====
// cht_pkg: shared types, codes and helper functions of the chained hash name table
// no dependencies; used by every module of the block and by its checker
package cht_pkg;

	localparam int POOL_NODES_DEF = 256;
	localparam int BUCKET_COUNT   = 26;
	localparam int BKT_W          = $clog2(BUCKET_COUNT);
	localparam int NAME_BYTES     = 9;

	localparam logic [7:0] CHAR_UPPER_A = 8'h41;
	localparam logic [7:0] CHAR_UPPER_Z = 8'h5a;
	localparam logic [7:0] CHAR_LOWER_A = 8'h61;
	localparam logic [7:0] CHAR_LOWER_Z = 8'h7a;
	localparam logic [7:0] CASE_OFFSET  = 8'h20;

	localparam logic OP_INSERT = 1'b0;
	localparam logic OP_SEARCH = 1'b1;

	typedef enum logic [1:0] {
		ST_DONE      = 2'd0,
		ST_NOT_FOUND = 2'd1,
		ST_FULL      = 2'd2,
		ST_BAD_KEY   = 2'd3
	} status_t;

	// one name: bytes 0..7 in head, byte 8 in tail
	typedef struct packed {
		logic [63:0] head;
		logic [7:0]  tail;
	} name_t;

	// payload of one pool node (the chain link lives in its own memory)
	typedef struct packed {
		name_t       fore;
		name_t       sur;
		logic [31:0] id;
	} node_t;

	// controller to datapath
	typedef struct packed {
		logic    capture;
		logic    insert;
		logic    rd_head;
		logic    rd_link;
		logic    res_load;
		status_t res_code;
		logic    res_found;
		logic    out_load;
	} cmd_t;

	// datapath to controller
	typedef struct packed {
		logic bad_key;
		logic op_search;
		logic pool_full;
		logic head_null;
		logic match;
		logic link_null;
		logic out_free;
	} sts_t;

	// zero every byte from the first zero byte on and beyond NAME_BYTES
	function automatic name_t name_tidy(input logic [63:0] head, input logic [7:0] tail);
		logic [7:0] b;
		logic       ended;
		name_t      w;
		ended = 1'b0;
		w     = '0;
		for (int i = 0; i < 9; i++) begin
			b = (i < 8) ? head[8*i +: 8] : tail;
			if ((i >= NAME_BYTES) || (b == 8'h00)) begin
				ended = 1'b1;
			end
			if (ended) begin
				b = 8'h00;
			end
			if (i < 8) begin
				w.head[8*i +: 8] = b;
			end else begin
				w.tail = b;
			end
		end
		return w;
	endfunction

	// first letter folded to lower case; valid low when not a letter
	function automatic logic [BKT_W:0] bucket_of(input name_t sur);
		logic [7:0] c;
		logic       ok;
		logic [7:0] d;
		c = sur.head[7:0];
		if (c inside {[CHAR_UPPER_A:CHAR_UPPER_Z]}) begin
			c = c + CASE_OFFSET;
		end
		ok = c inside {[CHAR_LOWER_A:CHAR_LOWER_Z]};
		d  = c - CHAR_LOWER_A;
		return {ok, d[BKT_W-1:0]};
	endfunction

endpackage

// ===== hw/rtl/chained_hash_name_table.sv =====
// chained_hash_name_table: top level of the chained hash name table
// depends on cht_pkg, cht_ctrl and cht_dp
//
//  channel | handshake            | payload
//  --------+----------------------+-----------------------------------------------------
//  in      | in_valid, in_stall   | op, forename_head/tail, surname_head/tail, record_id
//  out     | out_valid, out_stall | status, found_id
//
// an insert goes from acceptance through the hash state, which loads the result register,
// and the emit state into the output register; a search also walks its bucket's chain
// (skipped when the bucket is empty); the node pool has a single read port, so the chain
// walk costs one read per node; the next item is taken once the sequencer is back in idle
// reset empties all buckets at once; the pool itself needs no clearing
// one item is worked on at a time; the next is taken once the previous result is
// in the output register, even while that result is still stalled
module chained_hash_name_table #(
	parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic        op,
	input  logic [63:0] forename_head,
	input  logic [7:0]  forename_tail,
	input  logic [63:0] surname_head,
	input  logic [7:0]  surname_tail,
	input  logic [31:0] record_id,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [1:0]  status,
	output logic [31:0] found_id
);

	cht_pkg::cmd_t cmd;
	cht_pkg::sts_t sts;

	// sequencer: idle, hash and decide, walk the chain, hand over the result
	cht_ctrl u_ctrl (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_stall (in_stall),
		.sts      (sts),
		.cmd      (cmd)
	);

	// key capture, bucket heads, node pool and output register
	cht_dp #(
		.POOL_NODES (POOL_NODES)
	) u_dp (
		.clk           (clk),
		.arst_n        (arst_n),
		.op            (op),
		.forename_head (forename_head),
		.forename_tail (forename_tail),
		.surname_head  (surname_head),
		.surname_tail  (surname_tail),
		.record_id     (record_id),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.status        (status),
		.found_id      (found_id),
		.cmd           (cmd),
		.sts           (sts)
	);

endmodule

// ===== hw/rtl/cht_ctrl.sv =====
// cht_ctrl: sequencer of the chained hash name table
// depends on cht_pkg for command and status structs
module cht_ctrl (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          in_valid,
	output logic          in_stall,
	input  cht_pkg::sts_t sts,
	output cht_pkg::cmd_t cmd
);

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_HASH = 4'b0010,
		S_CMP  = 4'b0100,
		S_EMIT = 4'b1000
	} state_t;

	state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	assign in_stall = (state_q != S_IDLE);

	always_comb begin
		state_d = state_q;
		cmd     = '0;
		cmd.res_code = cht_pkg::ST_DONE;
		case (state_q)
			S_IDLE: begin
				if (in_valid) begin
					cmd.capture = 1'b1;
					state_d     = S_HASH;
				end
			end
			S_HASH: begin
				if (sts.bad_key) begin
					cmd.res_load = 1'b1;
					cmd.res_code = cht_pkg::ST_BAD_KEY;
					state_d      = S_EMIT;
				end else if (!sts.op_search) begin
					cmd.res_load = 1'b1;
					if (sts.pool_full) begin
						cmd.res_code = cht_pkg::ST_FULL;
					end else begin
						cmd.insert   = 1'b1;
						cmd.res_code = cht_pkg::ST_DONE;
					end
					state_d = S_EMIT;
				end else if (sts.head_null) begin
					cmd.res_load = 1'b1;
					cmd.res_code = cht_pkg::ST_NOT_FOUND;
					state_d      = S_EMIT;
				end else begin
					cmd.rd_head = 1'b1;
					state_d     = S_CMP;
				end
			end
			S_CMP: begin
				if (sts.match) begin
					cmd.res_load  = 1'b1;
					cmd.res_code  = cht_pkg::ST_DONE;
					cmd.res_found = 1'b1;
					state_d       = S_EMIT;
				end else if (sts.link_null) begin
					cmd.res_load = 1'b1;
					cmd.res_code = cht_pkg::ST_NOT_FOUND;
					state_d      = S_EMIT;
				end else begin
					cmd.rd_link = 1'b1;
				end
			end
			S_EMIT: begin
				if (sts.out_free) begin
					cmd.out_load = 1'b1;
					state_d      = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

endmodule

// ===== hw/rtl/cht_dp.sv =====
// cht_dp: key registers, bucket heads, node pool memory and result registers
// depends on cht_pkg for types, codes and the name and hash functions
module cht_dp #(
	parameter int POOL_NODES = cht_pkg::POOL_NODES_DEF
) (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          op,
	input  logic [63:0]   forename_head,
	input  logic [7:0]    forename_tail,
	input  logic [63:0]   surname_head,
	input  logic [7:0]    surname_tail,
	input  logic [31:0]   record_id,
	output logic          out_valid,
	input  logic          out_stall,
	output logic [1:0]    status,
	output logic [31:0]   found_id,
	input  cht_pkg::cmd_t cmd,
	output cht_pkg::sts_t sts
);

	localparam int PTR_W = $clog2(POOL_NODES + 1);
	localparam int IDX_W = $clog2(POOL_NODES);
	localparam logic [PTR_W-1:0] LINK_NONE = PTR_W'(POOL_NODES);

	// captured item
	logic                      op_q;
	cht_pkg::name_t            fore_q, sur_q;
	logic [31:0]               id_q;
	logic                      key_ok_q;
	logic [cht_pkg::BKT_W-1:0] bucket_q;
	logic [cht_pkg::BKT_W:0]   hash;

	// table state
	logic [PTR_W-1:0] heads_q [cht_pkg::BUCKET_COUNT];
	logic [PTR_W-1:0] used_q;
	logic [PTR_W-1:0] head_sel;

	// node pool
	cht_pkg::node_t   node_mem  [POOL_NODES];
	logic [PTR_W-1:0] link_mem  [POOL_NODES];
	cht_pkg::node_t   rd_node_q;
	logic [PTR_W-1:0] rd_link_q;
	logic [PTR_W-1:0] rd_addr;
	cht_pkg::node_t   wr_node;

	// result and output registers
	cht_pkg::status_t res_status_q;
	logic [31:0]      res_id_q;
	logic             out_valid_q;
	logic [1:0]       status_q;
	logic [31:0]      found_id_q;

	assign hash = cht_pkg::bucket_of(cht_pkg::name_tidy(surname_head, surname_tail));

	always_ff @(posedge clk) begin
		if (cmd.capture) begin
			op_q     <= op;
			fore_q   <= cht_pkg::name_tidy(forename_head, forename_tail);
			sur_q    <= cht_pkg::name_tidy(surname_head, surname_tail);
			id_q     <= record_id;
			key_ok_q <= hash[cht_pkg::BKT_W];
			bucket_q <= hash[cht_pkg::BKT_W-1:0];
		end
	end

	assign head_sel = heads_q[bucket_q];

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < cht_pkg::BUCKET_COUNT; i++) begin
				heads_q[i] <= LINK_NONE;
			end
			used_q <= '0;
		end else if (cmd.insert) begin
			heads_q[bucket_q] <= used_q;
			used_q            <= used_q + PTR_W'(1);
		end
	end

	// new node goes to the head of its chain
	assign wr_node = '{fore: fore_q, sur: sur_q, id: id_q};

	always_ff @(posedge clk) begin
		if (cmd.insert) begin
			node_mem[used_q[IDX_W-1:0]] <= wr_node;
			link_mem[used_q[IDX_W-1:0]] <= head_sel;
		end
	end

	assign rd_addr = cmd.rd_head ? head_sel : rd_link_q;

	always_ff @(posedge clk) begin
		if (cmd.rd_head || cmd.rd_link) begin
			rd_node_q <= node_mem[rd_addr[IDX_W-1:0]];
			rd_link_q <= link_mem[rd_addr[IDX_W-1:0]];
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.res_load) begin
			res_status_q <= cmd.res_code;
			res_id_q     <= cmd.res_found ? rd_node_q.id : 32'd0;
		end
		if (cmd.out_load) begin
			status_q   <= res_status_q;
			found_id_q <= res_id_q;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (cmd.out_load) begin
			out_valid_q <= 1'b1;
		end else if (!out_stall) begin
			out_valid_q <= 1'b0;
		end
	end

	assign out_valid = out_valid_q;
	assign status    = status_q;
	assign found_id  = found_id_q;

	assign sts.bad_key   = !key_ok_q;
	assign sts.op_search = (op_q == cht_pkg::OP_SEARCH);
	assign sts.pool_full = (used_q == LINK_NONE);
	assign sts.head_null = (head_sel == LINK_NONE);
	assign sts.match     = (rd_node_q.sur == sur_q) && (rd_node_q.fore == fore_q);
	assign sts.link_null = (rd_link_q == LINK_NONE);
	assign sts.out_free  = !out_valid_q || !out_stall;

endmodule

// ===== hw/rtl/cht_chk.sv =====
// cht_chk: port-level checker for the chained hash name table, bound to the top level
// depends on cht_pkg for the status codes
module cht_chk (
	input logic        clk,
	input logic        arst_n,
	input logic        in_valid,
	input logic        in_stall,
	input logic        out_valid,
	input logic        out_stall,
	input logic [1:0]  status,
	input logic [31:0] found_id
);

	// a stalled result holds
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_stall |=> out_valid && $stable(status) && $stable(found_id))
		else $error("stalled result changed");

	// a result with a failing status carries no id
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && (status != cht_pkg::ST_DONE) |-> found_id == 32'd0)
		else $error("id given with failing status");

	// one item at a time: busy right after taking an item
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall |=> in_stall)
		else $error("second item taken while busy");

	// no new result can be ready in the cycle after an item is taken, unless a stalled one is still held
	assert property (@(posedge clk) disable iff (!arst_n)
		in_valid && !in_stall && !(out_valid && out_stall) |=> !out_valid)
		else $error("result appeared too early");

endmodule

bind chained_hash_name_table cht_chk u_cht_chk (
	.clk       (clk),
	.arst_n    (arst_n),
	.in_valid  (in_valid),
	.in_stall  (in_stall),
	.out_valid (out_valid),
	.out_stall (out_stall),
	.status    (status),
	.found_id  (found_id)
);

// ===== sim/chained_hash_name_table_tb.sv =====
// testbench for chained_hash_name_table: inserts and searches name records, checks every result
// depends on cht_pkg and chained_hash_name_table; self-contained, no files or arguments
module testbench;
	timeunit 1ns;
	timeprecision 1ps;

	import cht_pkg::*;

	localparam int POOL_SIZE = POOL_NODES_DEF;
	localparam int NO_LINK   = POOL_SIZE;

	// one expected result
	typedef struct {
		status_t     code;
		logic [31:0] id;
	} lookup_result_t;

	// raw names of one record before any junk padding, kept for later searches
	typedef struct {
		name_t fore;
		name_t sur;
	} person_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        op            = OP_INSERT;
	logic [63:0] forename_head = '0;
	logic [7:0]  forename_tail = '0;
	logic [63:0] surname_head  = '0;
	logic [7:0]  surname_tail  = '0;
	logic [31:0] record_id     = '0;
	logic        out_stall     = 1'b0;
	logic        in_stall;
	logic        out_valid;
	logic [1:0]  status;
	logic [31:0] found_id;

	// predicted contents of the table: chain heads per bucket and the node pool
	int unsigned chain_top [BUCKET_COUNT];
	name_t       pool_fore [POOL_SIZE];
	name_t       pool_sur  [POOL_SIZE];
	logic [31:0] pool_id   [POOL_SIZE];
	int unsigned pool_next [POOL_SIZE];
	int unsigned pool_fill;

	lookup_result_t pending_results[$];
	person_t        known_people[$];
	int             fault_count = 0;
	// set during the stretch where neither side idles
	bit             no_idle = 1'b0;

	chained_hash_name_table #(
		.POOL_NODES(POOL_SIZE)
	) u_dut (
		.clk          (clk),
		.arst_n       (arst_n),
		.in_valid     (in_valid),
		.in_stall     (in_stall),
		.op           (op),
		.forename_head(forename_head),
		.forename_tail(forename_tail),
		.surname_head (surname_head),
		.surname_tail (surname_tail),
		.record_id    (record_id),
		.out_valid    (out_valid),
		.out_stall    (out_stall),
		.status       (status),
		.found_id     (found_id)
	);

	always #1 clk = ~clk;

	// generous ceiling: far above a run where every search walks a full chain
	initial begin
		#10_000_000;
		$display("testbench: done, errors");
		$finish;
	end

	// ---------------------------------------------------------------------------
	// predictor
	// ---------------------------------------------------------------------------

	// byte i of a name, head holding bytes 0..7 and tail byte 8
	function automatic logic [7:0] name_byte(input name_t n, input int i);
		return (i < 8) ? n.head[8*i +: 8] : n.tail;
	endfunction

	function automatic name_t set_byte(input name_t n, input int i, input logic [7:0] b);
		name_t r;
		r = n;
		if (i < 8) begin
			r.head[8*i +: 8] = b;
		end else begin
			r.tail = b;
		end
		return r;
	endfunction

	// a name ends at its first zero byte; everything after it counts as zero
	function automatic name_t clean_name(input name_t n);
		name_t r;
		logic  ended;
		r     = '0;
		ended = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (i >= NAME_BYTES || name_byte(n, i) == 8'h00) begin
				ended = 1'b1;
			end
			if (!ended) begin
				r = set_byte(r, i, name_byte(n, i));
			end
		end
		return r;
	endfunction

	// bucket from the surname's first letter, either case; -1 when not a letter
	function automatic int initial_slot(input name_t s);
		logic [7:0] c;
		c = s.head[7:0];
		if (c >= CHAR_UPPER_A && c <= CHAR_UPPER_Z) begin
			return int'(c - CHAR_UPPER_A);
		end
		if (c >= CHAR_LOWER_A && c <= CHAR_LOWER_Z) begin
			return int'(c - CHAR_LOWER_A);
		end
		return -1;
	endfunction

	// applies one item to the predicted table and gives the result it should produce
	function automatic lookup_result_t table_apply(input logic o, input name_t fore_raw,
			input name_t sur_raw, input logic [31:0] id);
		lookup_result_t r;
		name_t          f;
		name_t          s;
		int             slot;
		int unsigned    p;
		f      = clean_name(fore_raw);
		s      = clean_name(sur_raw);
		slot   = initial_slot(s);
		r.code = ST_NOT_FOUND;
		r.id   = '0;
		if (slot < 0) begin
			// bad key wins over everything, even a full pool
			r.code = ST_BAD_KEY;
		end else if (o == OP_INSERT) begin
			if (pool_fill >= POOL_SIZE) begin
				r.code = ST_FULL;
			end else begin
				// push the new node at the head of its chain
				pool_fore[pool_fill] = f;
				pool_sur[pool_fill]  = s;
				pool_id[pool_fill]   = id;
				pool_next[pool_fill] = chain_top[slot];
				chain_top[slot]      = pool_fill;
				pool_fill++;
				r.code = ST_DONE;
			end
		end else begin
			// newest first, so a duplicate finds its latest copy
			p = chain_top[slot];
			while (p != NO_LINK) begin
				if (pool_fore[p] == f && pool_sur[p] == s) begin
					r.code = ST_DONE;
					r.id   = pool_id[p];
					break;
				end
				p = pool_next[p];
			end
		end
		return r;
	endfunction

	// ---------------------------------------------------------------------------
	// name builders
	// ---------------------------------------------------------------------------

	function automatic name_t str_name(input string txt);
		name_t n;
		n = '0;
		for (int i = 0; i < txt.len() && i < 9; i++) begin
			n = set_byte(n, i, txt[i]);
		end
		return n;
	endfunction

	function automatic logic [7:0] any_letter();
		logic [7:0] c;
		c = CHAR_LOWER_A + 8'($urandom_range(0, 25));
		return ($urandom_range(0, 1) != 0) ? c - CASE_OFFSET : c;
	endfunction

	// junk after the terminator must not change what the name means
	function automatic name_t smear(input name_t n);
		name_t r;
		logic  ended;
		r     = n;
		ended = 1'b0;
		for (int i = 0; i < 9; i++) begin
			if (ended) begin
				r = set_byte(r, i, 8'($urandom_range(0, 255)));
			end else if (name_byte(n, i) == 8'h00) begin
				ended = 1'b1;
			end
		end
		return r;
	endfunction

	// 1 to 9 characters, plain letters or any non-zero byte
	function automatic name_t random_name(input bit letters_only);
		name_t n;
		int    len;
		n   = '0;
		len = $urandom_range(1, 9);
		for (int i = 0; i < len; i++) begin
			n = set_byte(n, i, letters_only ? any_letter() : 8'($urandom_range(1, 255)));
		end
		return n;
	endfunction

	// half the surnames crowd into the first four buckets so that chains grow long
	function automatic name_t random_surname();
		name_t      n;
		logic [7:0] c;
		n = random_name($urandom_range(0, 3) != 0);
		if ($urandom_range(0, 1) != 0) begin
			c = CHAR_LOWER_A + 8'($urandom_range(0, 3));
			if ($urandom_range(0, 1) != 0) begin
				c = c - CASE_OFFSET;
			end
		end else begin
			c = any_letter();
		end
		return set_byte(n, 0, c);
	endfunction

	// flip the case bit of one character inside the name
	function automatic name_t near_miss(input name_t n);
		int len;
		int pos;
		len = 0;
		while (len < 9 && name_byte(n, len) != 8'h00) begin
			len++;
		end
		pos = $urandom_range(0, len - 1);
		return set_byte(n, pos, name_byte(n, pos) ^ CASE_OFFSET);
	endfunction

	// ---------------------------------------------------------------------------
	// drive and check
	// ---------------------------------------------------------------------------

	// entered and left just after a rising edge; valid stays up between back-to-back items
	task automatic send_item(input logic o, input name_t fore, input name_t sur,
			input logic [31:0] id);
		lookup_result_t r;
		while (!no_idle && $urandom_range(0, 99) < 16) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid      <= 1'b1;
		op            <= o;
		forename_head <= fore.head;
		forename_tail <= fore.tail;
		surname_head  <= sur.head;
		surname_tail  <= sur.tail;
		record_id     <= id;
		@(posedge clk);
		while (in_stall) begin
			@(posedge clk);
		end
		r = table_apply(o, fore, sur, id);
		pending_results.push_back(r);
	endtask

	task automatic wait_for_drain();
		in_valid <= 1'b0;
		while (pending_results.size() != 0) begin
			@(posedge clk);
		end
	endtask

	// values sampled here are those from before the edge; the stall is redrawn afterwards
	always @(posedge clk) begin : result_check
		lookup_result_t want;
		if (arst_n && out_valid && !out_stall) begin
			if (pending_results.size() == 0) begin
				$error("result with none outstanding: status %0d, found_id %h", status, found_id);
				fault_count++;
			end else begin
				want = pending_results.pop_front();
				if (status !== want.code) begin
					$error("status: expected %0d, got %0d", want.code, status);
					fault_count++;
				end
				if (found_id !== want.id) begin
					$error("found_id: expected %h, got %h", want.id, found_id);
					fault_count++;
				end
			end
		end
		out_stall <= !no_idle && ($urandom_range(0, 99) < 16);
	end

	// ---------------------------------------------------------------------------
	// tests
	// ---------------------------------------------------------------------------

	// empty table, then surnames that do not start with a letter
	task automatic test_empty_and_bad_keys();
		name_t odd;
		send_item(OP_SEARCH, str_name("Ann"), str_name("Smith"), $urandom);
		send_item(OP_INSERT, str_name("Ann"), str_name(""), $urandom);
		send_item(OP_SEARCH, str_name("Ann"), str_name(""), $urandom);
		send_item(OP_INSERT, str_name("Ann"), str_name("@ndrews"), $urandom);
		send_item(OP_SEARCH, str_name("Ann"), str_name("[ane"), $urandom);
		send_item(OP_INSERT, str_name("Ann"), str_name("`ick"), $urandom);
		send_item(OP_SEARCH, str_name("Ann"), str_name("{ork"), $urandom);
		// empty surname with junk behind the terminator is still empty
		odd = '{head: 64'hffff_ffff_ffff_ff00, tail: 8'hff};
		send_item(OP_INSERT, str_name("Ann"), odd, 32'hffff_ffff);
		odd = set_byte(str_name("Xavier"), 0, 8'hff);
		send_item(OP_INSERT, str_name("Ann"), odd, $urandom);
		odd = set_byte(str_name("Xavier"), 0, 8'h80);
		send_item(OP_SEARCH, str_name("Ann"), odd, $urandom);
	endtask

	// inserts and hits, case sensitivity, duplicates, full nine-byte names and padding junk
	task automatic test_store_and_lookup();
		name_t jo;
		name_t young;
		jo    = str_name("Jo");
		young = str_name("Young");
		send_item(OP_INSERT, str_name("Ann"), str_name("Smith"), 32'h0000_0000);
		send_item(OP_INSERT, str_name("Bob"), str_name("SMITH"), 32'hffff_ffff);
		send_item(OP_INSERT, str_name("Alexandra"), str_name("Zimmerman"), 32'h1234_5678);
		send_item(OP_INSERT, str_name("Al"), str_name("aa"), 32'ha5a5_5a5a);
		send_item(OP_SEARCH, str_name("Ann"), str_name("Smith"), $urandom);
		send_item(OP_SEARCH, str_name("Bob"), str_name("SMITH"), $urandom);
		send_item(OP_SEARCH, str_name("Alexandra"), str_name("Zimmerman"), $urandom);
		send_item(OP_SEARCH, str_name("ann"), str_name("Smith"), $urandom);
		send_item(OP_SEARCH, str_name("Ann"), str_name("smith"), $urandom);
		// second copy of a record: the newer id wins
		send_item(OP_INSERT, str_name("Ann"), str_name("Smith"), 32'h0000_0005);
		send_item(OP_SEARCH, str_name("Ann"), str_name("Smith"), $urandom);
		send_item(OP_INSERT, smear(jo), smear(young), 32'h0000_004d);
		send_item(OP_SEARCH, jo, young, $urandom);
		send_item(OP_SEARCH, smear(jo), smear(young), $urandom);
		send_item(OP_SEARCH, str_name("Alexandr"), str_name("Zimmerman"), $urandom);
		send_item(OP_SEARCH, str_name("Al"), smear(str_name("aa")), $urandom);
	endtask

	// mostly well-formed traffic around stored records, with some near misses and noise
	task automatic test_random_mix(input int count);
		person_t who;
		name_t   f;
		name_t   s;
		int      pick;
		for (int k = 0; k < count; k++) begin
			pick = $urandom_range(0, 99);
			if (pick < 30 || known_people.size() == 0) begin
				if (known_people.size() != 0 && $urandom_range(0, 7) == 0) begin
					who = known_people[$urandom_range(0, known_people.size() - 1)];
				end else begin
					who.fore = random_name($urandom_range(0, 2) != 0);
					who.sur  = random_surname();
				end
				if (pool_fill < POOL_SIZE) begin
					known_people.push_back(who);
				end
				send_item(OP_INSERT, smear(who.fore), smear(who.sur), $urandom);
			end else if (pick < 70) begin
				who = known_people[$urandom_range(0, known_people.size() - 1)];
				send_item(OP_SEARCH, smear(who.fore), smear(who.sur), $urandom);
			end else if (pick < 85) begin
				who = known_people[$urandom_range(0, known_people.size() - 1)];
				f   = who.fore;
				s   = who.sur;
				if ($urandom_range(0, 1) != 0) begin
					f = near_miss(f);
				end else begin
					s = near_miss(s);
				end
				send_item(OP_SEARCH, f, s, $urandom);
			end else begin
				// raw noise on every field; half of it gets a letter up front to pass hashing
				f = '{head: {$urandom, $urandom}, tail: 8'($urandom)};
				s = '{head: {$urandom, $urandom}, tail: 8'($urandom)};
				if ($urandom_range(0, 1) != 0) begin
					s = set_byte(s, 0, any_letter());
				end
				send_item(logic'($urandom_range(0, 1)), f, s, $urandom);
			end
		end
	endtask

	// fill the pool to the last node, then inserts are refused unless the key is bad
	task automatic test_pool_exhaustion();
		person_t who;
		wait_for_drain();
		while (pool_fill < POOL_SIZE) begin
			who.fore = random_name(1'b1);
			who.sur  = random_surname();
			known_people.push_back(who);
			send_item(OP_INSERT, who.fore, who.sur, $urandom);
		end
		for (int k = 0; k < 3; k++) begin
			send_item(OP_INSERT, random_name(1'b1), random_surname(), $urandom);
		end
		send_item(OP_INSERT, str_name("Nine"), str_name("9lives"), $urandom);
		send_item(OP_SEARCH, str_name("Nine"), str_name("9lives"), $urandom);
		for (int k = 0; k < 2; k++) begin
			who = known_people[$urandom_range(0, known_people.size() - 1)];
			send_item(OP_SEARCH, who.fore, who.sur, $urandom);
		end
	endtask

	// ---------------------------------------------------------------------------
	// sequence
	// ---------------------------------------------------------------------------

	initial begin
		for (int i = 0; i < BUCKET_COUNT; i++) begin
			chain_top[i] = NO_LINK;
		end
		pool_fill = 0;

		repeat (5) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_empty_and_bad_keys();
		test_store_and_lookup();
		test_random_mix(700);
		// this one first lets every outstanding result come back
		test_pool_exhaustion();
		no_idle = 1'b1;
		test_random_mix(300);
		no_idle = 1'b0;
		wait_for_drain();
		test_random_mix(850);

		wait_for_drain();
		// room for a full chain walk, so a stray late result is still caught
		repeat (300) @(posedge clk);
		if (fault_count == 0) begin
			$display("testbench: done, clean");
		end else begin
			$display("testbench: done, errors");
		end
		$finish;
	end

endmodule

// ===== files.f =====
hw/rtl/cht_pkg.sv
hw/rtl/cht_ctrl.sv
hw/rtl/cht_dp.sv
hw/rtl/chained_hash_name_table.sv
hw/rtl/cht_chk.sv
sim/chained_hash_name_table_tb.sv
